// ----- rtl/core/drr_pkg.sv -----
package drr_pkg;

   // defaults for the top-level parameters
   localparam int SETS_DEF        = 2048;
   localparam int WAYS_DEF        = 16;
   localparam int LEADER_SETS_DEF = 64;
   localparam int DUEL_WIDTH_DEF  = 10;

   // transaction field widths
   localparam int SET_INDEX_W = 11;
   localparam int WAY_INDEX_W = 4;
   localparam int BLOCK_W     = 32;
   localparam int DRAW_W      = 5;
   localparam int VICTIM_W    = 4;

   // wide enough for any way number (WAYS <= 32)
   localparam int WAY_FIELD_W = 5;

   // restoring steps for set % SETS (SETS >= 64) and way % WAYS (WAYS >= 2)
   localparam int SET_MOD_STEPS = 5;
   localparam int WAY_MOD_STEPS = 3;

   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_NEAR = 2'd2;
   localparam logic [1:0] RRPV_HIT  = 2'd0;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FOLLOW = 2'd0;
   localparam kind_type KIND_SRRIP  = 2'd1;
   localparam kind_type KIND_BRRIP  = 2'd2;

   localparam logic REQ_VICTIM = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   typedef struct packed {
      logic                   found;
      logic [WAY_FIELD_W-1:0] way;
   } search_type;

endpackage

// ----- rtl/core/drr_if.sv -----
interface drr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [drr_pkg::SET_INDEX_W-1:0]     set_index;
   logic [drr_pkg::WAY_INDEX_W-1:0]     way_index;
   logic [drr_pkg::BLOCK_W-1:0]         block_address;
   logic                                was_hit;
   logic [drr_pkg::DRAW_W-1:0]          random_draw;

   modport source (output valid, req_type, set_index, way_index, block_address, was_hit,
                   random_draw, input ready);
   modport sink   (input valid, req_type, set_index, way_index, block_address, was_hit,
                   random_draw, output ready);
endinterface

interface drr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [drr_pkg::VICTIM_W-1:0]    victim_way;

   modport source (output valid, victim_way, input ready);
   modport sink   (input valid, victim_way, output ready);
endinterface

// ----- rtl/core/drr_ram.sv -----
module drr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/drr_row_unit.sv -----
// Shared age/search unit: saturating add to every RRPV, then first-way search
// over either the RRPV==3 mask or the dead mask. Also reports 3 - max(RRPV).
module drr_row_unit #(
   parameter int WAYS = drr_pkg::WAYS_DEF
) (
   input  logic [2*WAYS-1:0]       rrpv_row,
   input  logic [WAYS-1:0]         dead_row,
   input  logic [1:0]              amount,
   input  logic                    sel_dead,
   output logic [2*WAYS-1:0]       aged_row,
   output drr_pkg::search_type     search,
   output logic [1:0]              gap
);

   logic [WAYS-1:0] at_max;
   logic [WAYS-1:0] mask;
   logic            any_max;
   logic            any_hi;
   logic            any_nz;

   always_comb begin
      logic [2:0] sum;
      any_max = 1'b0;
      any_hi  = 1'b0;
      any_nz  = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         sum = {1'b0, rrpv_row[2*i +: 2]} + {1'b0, amount};
         aged_row[2*i +: 2] = (sum > {1'b0, drr_pkg::RRPV_MAX}) ? drr_pkg::RRPV_MAX : sum[1:0];
         at_max[i] = (aged_row[2*i +: 2] == drr_pkg::RRPV_MAX);
         any_max = any_max | (rrpv_row[2*i +: 2] == drr_pkg::RRPV_MAX);
         any_hi  = any_hi | rrpv_row[2*i + 1];
         any_nz  = any_nz | (|rrpv_row[2*i +: 2]);
      end
   end

   assign mask = sel_dead ? dead_row : at_max;

   // lowest set bit wins
   always_comb begin
      search = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            search.found = 1'b1;
            search.way   = drr_pkg::WAY_FIELD_W'(i);
         end
      end
   end

   always_comb begin
      priority if (any_max) begin
         gap = 2'd0;
      end else if (any_hi) begin
         gap = 2'd1;
      end else if (any_nz) begin
         gap = 2'd2;
      end else begin
         gap = 2'd3;
      end
   end

endmodule

// ----- rtl/core/drr_upd_unit.sv -----
// Update after an access: stream detector, hit promotion / fill insertion,
// dead flag and duel counter movement.
module drr_upd_unit #(
   parameter int WAYS       = drr_pkg::WAYS_DEF,
   parameter int DUEL_WIDTH = drr_pkg::DUEL_WIDTH_DEF
) (
   input  logic [2*WAYS-1:0]          rrpv_row,
   input  logic [WAYS-1:0]            dead_row,
   input  logic                       stream_bit,
   input  logic [drr_pkg::BLOCK_W-1:0] prev_block,
   input  drr_pkg::kind_type          kind,
   input  logic [$clog2(WAYS)-1:0]    way,
   input  logic [drr_pkg::BLOCK_W-1:0] block_address,
   input  logic                       was_hit,
   input  logic [drr_pkg::DRAW_W-1:0] random_draw,
   input  logic [DUEL_WIDTH-1:0]      duel,
   output logic [2*WAYS-1:0]          rrpv_new,
   output logic [WAYS-1:0]            dead_new,
   output logic                       stream_new,
   output logic [DUEL_WIDTH-1:0]      duel_new
);

   localparam int WAY_BITS = $clog2(WAYS);
   localparam logic [DUEL_WIDTH-1:0] DUEL_MID = {1'b1, {(DUEL_WIDTH-1){1'b0}}};

   logic [drr_pkg::BLOCK_W-1:0] delta;
   logic                        prev_nz;
   logic                        step_one;
   logic [1:0]                  bimodal;
   logic [1:0]                  ins;
   logic [1:0]                  fill_rrpv;

   assign delta    = block_address - prev_block;
   assign prev_nz  = |prev_block;
   assign step_one = (delta == drr_pkg::BLOCK_W'(1)) || (&delta);

   always_comb begin
      priority if (prev_nz && step_one) begin
         stream_new = 1'b1;
      end else if (prev_nz && (|delta)) begin
         stream_new = 1'b0;
      end else begin
         stream_new = stream_bit;
      end
   end

   assign bimodal = (random_draw == '0) ? drr_pkg::RRPV_NEAR : drr_pkg::RRPV_MAX;

   always_comb begin
      priority if (kind == drr_pkg::KIND_SRRIP) begin
         ins = drr_pkg::RRPV_NEAR;
      end else if (kind == drr_pkg::KIND_BRRIP) begin
         ins = bimodal;
      end else begin
         ins = (duel >= DUEL_MID) ? drr_pkg::RRPV_NEAR : bimodal;
      end
   end

   assign fill_rrpv = stream_new ? drr_pkg::RRPV_MAX : ins;

   always_comb begin
      rrpv_new = rrpv_row;
      dead_new = dead_row;
      for (int i = 0; i < WAYS; i++) begin
         if (way == WAY_BITS'(i)) begin
            rrpv_new[2*i +: 2] = was_hit ? drr_pkg::RRPV_HIT : fill_rrpv;
            dead_new[i]        = was_hit ? 1'b0 : stream_new;
         end
      end
   end

   // leader-set hits steer the duel, saturating at both ends
   always_comb begin
      duel_new = duel;
      if (was_hit) begin
         priority if (kind == drr_pkg::KIND_SRRIP && !(&duel)) begin
            duel_new = duel + DUEL_WIDTH'(1);
         end else if (kind == drr_pkg::KIND_BRRIP && (|duel)) begin
            duel_new = duel - DUEL_WIDTH'(1);
         end
      end
   end

endmodule

// ----- rtl/core/drrip_streaming_dead_block_replacement_unit.sv -----
// Victim request: load, 1-4 passes through the shared age/search unit, row
//   write-back, then rsp valid. Update: load, update, row write-back.
// One transaction in flight; the next is taken the cycle after the row write-back,
//   so a request is not taken before the last one is through, a limit set by the row
//   RAM read-modify-write and the single age/search unit; a victim whose response
//   cannot go out because the previous one is still held stays in write-back.
// Reset is synchronous; afterward a clearing pass initializes the row RAM and
//   leader marks while req ready stays low.
module drrip_streaming_dead_block_replacement_unit #(
   parameter int SETS        = drr_pkg::SETS_DEF,
   parameter int WAYS        = drr_pkg::WAYS_DEF,
   parameter int LEADER_SETS = drr_pkg::LEADER_SETS_DEF,
   parameter int DUEL_WIDTH  = drr_pkg::DUEL_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   drr_req_if.sink    req_chan,
   drr_rsp_if.source  rsp_chan
);

   localparam int SET_BITS  = $clog2(SETS);
   localparam int WAY_BITS  = $clog2(WAYS);
   localparam int POS_BITS  = $clog2(SETS + 1);
   localparam int LEAD_BITS = $clog2(LEADER_SETS + 1);
   localparam int REM_BITS  = $clog2(LEADER_SETS) + 1;
   localparam int STEP_Q    = SETS / LEADER_SETS;
   localparam int STEP_R    = SETS % LEADER_SETS;
   localparam int HALF_LEAD = LEADER_SETS / 2;

   // row layout: {kind, prev_block, stream, dead[WAYS], rrpv[2*WAYS]}
   localparam int DEAD_LSB   = 2 * WAYS;
   localparam int STREAM_POS = 3 * WAYS;
   localparam int PREV_LSB   = 3 * WAYS + 1;
   localparam int KIND_LSB   = PREV_LSB + drr_pkg::BLOCK_W;
   localparam int ROW_W      = KIND_LSB + 2;

   localparam logic [DUEL_WIDTH-1:0] DUEL_MID = {1'b1, {(DUEL_WIDTH-1){1'b0}}};

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_STREAM = 3'd3;
   localparam logic [2:0] ST_DEAD   = 3'd4;
   localparam logic [2:0] ST_AGE    = 3'd5;
   localparam logic [2:0] ST_UPDATE = 3'd6;
   localparam logic [2:0] ST_WRITE  = 3'd7;

   logic [2:0]                   state_ff, state_in;

   // clearing pass and leader placement
   logic [SET_BITS-1:0]          clr_addr_ff, clr_addr_in;
   logic [LEAD_BITS-1:0]         lead_i_ff, lead_i_in;
   logic [POS_BITS-1:0]          lead_q_ff, lead_q_in;
   logic [REM_BITS-1:0]          lead_r_ff, lead_r_in;
   drr_pkg::kind_type            lead_kind_ff, lead_kind_in;
   logic                         lead_hit;
   logic [REM_BITS-1:0]          r_sum;
   logic                         r_carry;

   // latched transaction
   logic [SET_BITS-1:0]          set_ff, set_in;
   logic [WAY_BITS-1:0]          way_ff, way_in;
   logic [drr_pkg::BLOCK_W-1:0]  blk_ff, blk_in;
   logic                         hit_ff, hit_in;
   logic [drr_pkg::DRAW_W-1:0]   draw_ff, draw_in;
   logic                         upd_ff, upd_in;

   // working copy of the set row
   logic [2*WAYS-1:0]            rrpv_ff, rrpv_in;
   logic [WAYS-1:0]              dead_ff, dead_in;
   logic                         stream_ff, stream_in;
   logic [drr_pkg::BLOCK_W-1:0]  prev_ff, prev_in;
   drr_pkg::kind_type            kind_ff, kind_in;
   logic [1:0]                   amt_ff, amt_in;
   logic [WAY_BITS-1:0]          victim_ff, victim_in;

   logic [DUEL_WIDTH-1:0]        duel_ff, duel_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [drr_pkg::VICTIM_W-1:0] rsp_way_ff, rsp_way_in;

   // row RAM port
   logic                         wr_en;
   logic [SET_BITS-1:0]          wr_addr;
   logic [ROW_W-1:0]             wr_data;
   logic                         rd_en;
   logic [ROW_W-1:0]             rd_data;

   // index folding
   logic [drr_pkg::SET_INDEX_W-1:0] set_rem;
   logic [drr_pkg::WAY_INDEX_W-1:0] way_rem;

   // shared unit
   logic [2*WAYS-1:0]            aged_row;
   drr_pkg::search_type          search;
   logic [1:0]                   gap;

   // update unit
   logic [2*WAYS-1:0]            upd_rrpv;
   logic [WAYS-1:0]              upd_dead;
   logic                         upd_stream;
   logic [DUEL_WIDTH-1:0]        upd_duel;

   logic                         accept;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.victim_way = rsp_way_ff;

   // set_index % SETS and way_index % WAYS by restoring subtraction
   always_comb begin
      set_rem = req_chan.set_index;
      for (int k = drr_pkg::SET_MOD_STEPS - 1; k >= 0; k--) begin
         if (int'(set_rem) >= (SETS << k)) begin
            set_rem = set_rem - drr_pkg::SET_INDEX_W'(SETS << k);
         end
      end
   end

   always_comb begin
      way_rem = req_chan.way_index;
      for (int k = drr_pkg::WAY_MOD_STEPS - 1; k >= 0; k--) begin
         if (int'(way_rem) >= (WAYS << k)) begin
            way_rem = way_rem - drr_pkg::WAY_INDEX_W'(WAYS << k);
         end
      end
   end

   drr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (SET_BITS'(set_rem)),
      .rd_data (rd_data)
   );

   drr_row_unit #(
      .WAYS (WAYS)
   ) u_row_unit (
      .rrpv_row (rrpv_ff),
      .dead_row (dead_ff),
      .amount   (amt_ff),
      .sel_dead (state_ff == ST_DEAD),
      .aged_row (aged_row),
      .search   (search),
      .gap      (gap)
   );

   drr_upd_unit #(
      .WAYS       (WAYS),
      .DUEL_WIDTH (DUEL_WIDTH)
   ) u_upd_unit (
      .rrpv_row      (rrpv_ff),
      .dead_row      (dead_ff),
      .stream_bit    (stream_ff),
      .prev_block    (prev_ff),
      .kind          (kind_ff),
      .way           (way_ff),
      .block_address (blk_ff),
      .was_hit       (hit_ff),
      .random_draw   (draw_ff),
      .duel          (duel_ff),
      .rrpv_new      (upd_rrpv),
      .dead_new      (upd_dead),
      .stream_new    (upd_stream),
      .duel_new      (upd_duel)
   );

   // Leader set i sits at floor(i*SETS/LEADER_SETS); track that position with a
   // quotient/remainder pair. Several leaders may land on one set (later wins),
   // so the sweep holds its address until all of them are consumed.
   assign lead_hit = (lead_i_ff != LEAD_BITS'(LEADER_SETS)) &&
                     (lead_q_ff == POS_BITS'(clr_addr_ff));
   assign r_sum    = lead_r_ff + REM_BITS'(STEP_R);
   assign r_carry  = (r_sum >= REM_BITS'(LEADER_SETS));

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      lead_i_in    = lead_i_ff;
      lead_q_in    = lead_q_ff;
      lead_r_in    = lead_r_ff;
      lead_kind_in = lead_kind_ff;
      set_in       = set_ff;
      way_in       = way_ff;
      blk_in       = blk_ff;
      hit_in       = hit_ff;
      draw_in      = draw_ff;
      upd_in       = upd_ff;
      rrpv_in      = rrpv_ff;
      dead_in      = dead_ff;
      stream_in    = stream_ff;
      prev_in      = prev_ff;
      kind_in      = kind_ff;
      amt_in       = amt_ff;
      victim_in    = victim_ff;
      duel_in      = duel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_way_in   = rsp_way_ff;
      wr_en        = 1'b0;
      wr_addr      = set_ff;
      wr_data      = {kind_ff, prev_ff, stream_ff, dead_ff, rrpv_ff};
      rd_en        = accept;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_addr_ff;
            wr_data = {lead_kind_ff, {drr_pkg::BLOCK_W{1'b0}}, 1'b0, {WAYS{1'b0}},
                       {(2*WAYS){1'b1}}};
            if (lead_hit) begin
               lead_kind_in = (lead_i_ff < LEAD_BITS'(HALF_LEAD)) ? drr_pkg::KIND_SRRIP
                                                                   : drr_pkg::KIND_BRRIP;
               lead_i_in    = lead_i_ff + LEAD_BITS'(1);
               lead_r_in    = r_carry ? (r_sum - REM_BITS'(LEADER_SETS)) : r_sum;
               lead_q_in    = lead_q_ff + POS_BITS'(STEP_Q) + POS_BITS'(r_carry);
            end else begin
               wr_en        = 1'b1;
               lead_kind_in = drr_pkg::KIND_FOLLOW;
               clr_addr_in  = clr_addr_ff + SET_BITS'(1);
               if (clr_addr_ff == SET_BITS'(SETS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            if (accept) begin
               set_in   = SET_BITS'(set_rem);
               way_in   = WAY_BITS'(way_rem);
               blk_in   = req_chan.block_address;
               hit_in   = req_chan.was_hit;
               draw_in  = req_chan.random_draw;
               upd_in   = (req_chan.req_type == drr_pkg::REQ_UPDATE);
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            rrpv_in   = rd_data[DEAD_LSB-1:0];
            dead_in   = rd_data[STREAM_POS-1:DEAD_LSB];
            stream_in = rd_data[STREAM_POS];
            prev_in   = rd_data[KIND_LSB-1:PREV_LSB];
            kind_in   = rd_data[ROW_W-1:KIND_LSB];
            amt_in    = 2'd0;
            priority if (upd_ff) begin
               state_in = ST_UPDATE;
            end else if (rd_data[STREAM_POS]) begin
               state_in = ST_STREAM;
            end else begin
               state_in = ST_DEAD;
            end
         end

         // streaming set: look for RRPV 3, then once more after aging by one
         ST_STREAM: begin
            priority if (search.found) begin
               rrpv_in   = aged_row;
               victim_in = search.way[WAY_BITS-1:0];
               state_in  = ST_WRITE;
            end else if (amt_ff == 2'd0) begin
               amt_in = 2'd1;
            end else begin
               rrpv_in  = aged_row;
               state_in = ST_DEAD;
            end
         end

         ST_DEAD: begin
            if (search.found) begin
               victim_in = search.way[WAY_BITS-1:0];
               state_in  = ST_WRITE;
            end else begin
               amt_in   = gap;
               state_in = ST_AGE;
            end
         end

         // SRRIP: age by 3 - max so some way reaches 3; first such way goes
         ST_AGE: begin
            rrpv_in   = aged_row;
            victim_in = search.way[WAY_BITS-1:0];
            state_in  = ST_WRITE;
         end

         ST_UPDATE: begin
            rrpv_in   = upd_rrpv;
            dead_in   = upd_dead;
            stream_in = upd_stream;
            prev_in   = blk_ff;
            duel_in   = upd_duel;
            state_in  = ST_WRITE;
         end

         // write-back is idempotent, so a stall on the response is harmless
         ST_WRITE: begin
            wr_en = 1'b1;
            priority if (upd_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = drr_pkg::VICTIM_W'(victim_ff);
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         lead_i_ff    <= '0;
         lead_q_ff    <= '0;
         lead_r_ff    <= '0;
         lead_kind_ff <= drr_pkg::KIND_FOLLOW;
         duel_ff      <= DUEL_MID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         lead_i_ff    <= lead_i_in;
         lead_q_ff    <= lead_q_in;
         lead_r_ff    <= lead_r_in;
         lead_kind_ff <= lead_kind_in;
         duel_ff      <= duel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff     <= set_in;
      way_ff     <= way_in;
      blk_ff     <= blk_in;
      hit_ff     <= hit_in;
      draw_ff    <= draw_in;
      upd_ff     <= upd_in;
      rrpv_ff    <= rrpv_in;
      dead_ff    <= dead_in;
      stream_ff  <= stream_in;
      prev_ff    <= prev_in;
      kind_ff    <= kind_in;
      amt_ff     <= amt_in;
      victim_ff  <= victim_in;
      rsp_way_ff <= rsp_way_in;
   end

   // SRRIP aging always leaves some way at RRPV 3
   a_age_finds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AGE |-> search.found)
      else $error("aging pass found no way at max RRPV");

   a_stream_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> stream_ff)
      else $error("streaming search on a set without stream bit");

   a_duel_only_on_update: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_UPDATE |=> $stable(duel_ff))
      else $error("duel counter moved outside an update");

   a_rsp_from_victim: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE) && !$past(upd_ff))
      else $error("response raised without a victim write-back");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("response pending during clearing pass");

endmodule

// ----- test/tb_drrip_streaming_dead_block_replacement_unit.sv -----
`timescale 1ns / 100ps

module tb_drrip_streaming_dead_block_replacement_unit;

   localparam int N_SETS    = drr_pkg::SETS_DEF;
   localparam int N_WAYS    = drr_pkg::WAYS_DEF;
   localparam int N_LEADERS = drr_pkg::LEADER_SETS_DEF;
   localparam int DUEL_W    = drr_pkg::DUEL_WIDTH_DEF;
   localparam int SET_W     = drr_pkg::SET_INDEX_W;
   localparam int WAY_W     = drr_pkg::WAY_INDEX_W;
   localparam int BLK_W     = drr_pkg::BLOCK_W;
   localparam int DRW_W     = drr_pkg::DRAW_W;
   localparam int VIC_W     = drr_pkg::VICTIM_W;
   localparam logic OP_VIC  = drr_pkg::REQ_VICTIM;
   localparam logic OP_UPD  = drr_pkg::REQ_UPDATE;
   localparam logic [DUEL_W-1:0] DUEL_MID = DUEL_W'(1 << (DUEL_W - 1));
   localparam logic [DUEL_W-1:0] DUEL_TOP = '1;

   // quiet cycles before giving up; covers the clearing pass plus the long receiver
   // hold-off with plenty of margin
   localparam int QUIET_LIMIT  = 10000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int ITEMS_PER_MODE = 342;

   typedef struct {
      logic                   op;
      logic [SET_W-1:0]       set_idx;
      logic [WAY_W-1:0]       way;
      logic [BLK_W-1:0]       blk;
      logic                   hit;
      logic [DRW_W-1:0]       draw;
      bit                     typed;     // victim below is hand-computed
      logic [VIC_W-1:0]       victim;
   } stim_row_type;

   logic clock;
   logic reset;

   drr_req_if req_chan ();
   drr_rsp_if rsp_chan ();

   drrip_streaming_dead_block_replacement_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ------------------------------------------------------------------
   // Policy predictor state: one copy of every per-set store
   // ------------------------------------------------------------------
   logic [2*N_WAYS-1:0] rrpv_rows    [N_SETS];
   logic [N_WAYS-1:0]   dead_rows    [N_SETS];
   logic                stream_flags [N_SETS];
   logic [BLK_W-1:0]    last_block   [N_SETS];
   drr_pkg::kind_type   leader_map   [N_SETS];
   logic [DUEL_W-1:0]   duel_count;

   // victim ways still owed by the block, oldest first
   logic [VIC_W-1:0] victim_queue [$];

   // stimulus side: last block address sent per set, for building +/-1 runs
   logic [BLK_W-1:0]    gen_last [N_SETS];
   stim_row_type        directed_rows [$];
   stim_row_type        offer;

   logic [SET_W-1:0] busy_sets [8] = '{11'd0, 11'd32, 11'd1024, 11'd1056,
                                      11'd5, 11'd777, 11'd1500, 11'd2047};

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  stall_req;
   int  fail_count;
   int  quiet_cycles;
   int  checked_victims;
   int  applied_updates;
   int  picks_stream, picks_stream_aged, picks_dead, picks_srrip_aged;
   logic [DUEL_W-1:0] duel_lo, duel_hi;
   logic [VIC_W-1:0] want;

   // ------------------------------------------------------------------
   // Predictor helpers
   // ------------------------------------------------------------------
   function automatic int first_at_max(logic [2*N_WAYS-1:0] row);
      for (int w = 0; w < N_WAYS; w++)
         if (row[2*w +: 2] == drr_pkg::RRPV_MAX)
            return w;
      return -1;
   endfunction

   // raise every RRPV by amount, saturating at the max
   function automatic logic [2*N_WAYS-1:0] aged_row(logic [2*N_WAYS-1:0] row, int amount);
      int v;
      for (int w = 0; w < N_WAYS; w++) begin
         v = int'(row[2*w +: 2]) + amount;
         row[2*w +: 2] = (v > int'(drr_pkg::RRPV_MAX)) ? drr_pkg::RRPV_MAX : 2'(v);
      end
      return row;
   endfunction

   // victim choice; may age the set, which sticks
   function automatic logic [VIC_W-1:0] predict_victim(int s);
      logic [2*N_WAYS-1:0] row;
      int found;
      int top;
      row = rrpv_rows[s];
      top = 0;
      if (stream_flags[s]) begin
         found = first_at_max(row);
         if (found >= 0) begin
            picks_stream++;
            return VIC_W'(found);
         end
         row = aged_row(row, 1);
         rrpv_rows[s] = row;
         found = first_at_max(row);
         if (found >= 0) begin
            picks_stream_aged++;
            return VIC_W'(found);
         end
      end
      for (int w = 0; w < N_WAYS; w++)
         if (dead_rows[s][w]) begin
            picks_dead++;
            return VIC_W'(w);
         end
      for (int w = 0; w < N_WAYS; w++)
         if (int'(row[2*w +: 2]) > top)
            top = int'(row[2*w +: 2]);
      if (top < int'(drr_pkg::RRPV_MAX))
         picks_srrip_aged++;
      row = aged_row(row, int'(drr_pkg::RRPV_MAX) - top);
      rrpv_rows[s] = row;
      found = first_at_max(row);
      return (found >= 0) ? VIC_W'(found) : '0;
   endfunction

   // streaming detector, dead flags, insertion and set dueling
   function automatic void apply_access(int s, int w, logic [BLK_W-1:0] blk, logic hit,
                                        logic [DRW_W-1:0] draw);
      logic [BLK_W-1:0]   delta;
      logic [1:0]         bimodal;
      logic [1:0]         ins;
      drr_pkg::kind_type  kind;
      delta   = blk - last_block[s];
      kind    = leader_map[s];
      bimodal = (draw == '0) ? drr_pkg::RRPV_NEAR : drr_pkg::RRPV_MAX;
      if (last_block[s] != '0 && (delta == BLK_W'(1) || delta == '1))
         stream_flags[s] = 1'b1;
      else if (last_block[s] != '0 && delta != '0)
         stream_flags[s] = 1'b0;
      last_block[s] = blk;

      if (hit) begin
         rrpv_rows[s][2*w +: 2] = drr_pkg::RRPV_HIT;
         dead_rows[s][w] = 1'b0;
         if (kind == drr_pkg::KIND_SRRIP && duel_count != DUEL_TOP)
            duel_count++;
         else if (kind == drr_pkg::KIND_BRRIP && duel_count != '0)
            duel_count--;
         if (duel_count < duel_lo) duel_lo = duel_count;
         if (duel_count > duel_hi) duel_hi = duel_count;
         return;
      end

      dead_rows[s][w] = stream_flags[s];
      if (kind == drr_pkg::KIND_SRRIP)
         ins = drr_pkg::RRPV_NEAR;
      else if (kind == drr_pkg::KIND_BRRIP)
         ins = bimodal;
      else
         ins = (duel_count >= DUEL_MID) ? drr_pkg::RRPV_NEAR : bimodal;
      rrpv_rows[s][2*w +: 2] = stream_flags[s] ? drr_pkg::RRPV_MAX : ins;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus rows
   // ------------------------------------------------------------------
   function automatic stim_row_type row_of(logic op, int s, int w, logic [BLK_W-1:0] blk,
                                           logic hit, int draw, bit typed, int victim);
      stim_row_type r;
      r.op      = op;
      r.set_idx = SET_W'(s);
      r.way     = WAY_W'(w);
      r.blk     = blk;
      r.hit     = hit;
      r.draw    = DRW_W'(draw);
      r.typed   = typed;
      r.victim  = VIC_W'(victim);
      return r;
   endfunction

   // Mostly well-formed traffic on a few busy sets (leaders and followers), with
   // +/-1 address runs to trip the streaming detector. Mode 0 leans on SRRIP
   // leader hits and mode 1 on BRRIP leader hits so the duel counter swings
   // across its midpoint in both directions.
   function automatic stim_row_type random_row(int mode);
      stim_row_type       r;
      int                 pick;
      int                 c;
      logic [BLK_W-1:0]   base;
      r.typed  = 1'b0;
      r.victim = '0;
      r.way    = WAY_W'($urandom_range(N_WAYS - 1));
      r.draw   = ($urandom_range(2) == 0) ? '0 : DRW_W'($urandom_range(31));
      pick     = $urandom_range(99);
      if (mode == 0 && pick < 40) begin
         r.op      = OP_UPD;
         r.hit     = 1'b1;
         r.set_idx = SET_W'($urandom_range(N_LEADERS / 2 - 1) * (N_SETS / N_LEADERS));
      end else if (mode == 1 && pick < 50) begin
         r.op      = OP_UPD;
         r.hit     = 1'b1;
         r.set_idx = SET_W'((N_LEADERS / 2 + $urandom_range(N_LEADERS / 2 - 1))
                            * (N_SETS / N_LEADERS));
      end else begin
         r.set_idx = ($urandom_range(9) == 0) ? SET_W'($urandom)
                                              : busy_sets[$urandom_range(7)];
         c    = $urandom_range(99);
         r.op  = (c < 30) ? OP_VIC : OP_UPD;
         r.hit = (c < 65);
      end
      base = gen_last[r.set_idx];
      c    = $urandom_range(99);
      if (c < 55)
         r.blk = $urandom_range(1) ? base + 1 : base - 1;
      else if (c < 65)
         r.blk = base;
      else if (c < 70)
         r.blk = '0;
      else
         r.blk = $urandom;
      return r;
   endfunction

   // Offer one transaction and hold it until the block takes it. Called at a
   // rising edge; random idle cycles go in front of the offer.
   task automatic send_row(stim_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= r.op;
      req_chan.set_index     <= r.set_idx;
      req_chan.way_index     <= r.way;
      req_chan.block_address <= r.blk;
      req_chan.was_hit       <= r.hit;
      req_chan.random_draw   <= r.draw;
      offer                  <= r;
      if (r.op == OP_UPD)
         gen_last[r.set_idx] = r.blk;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Result receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_req) begin
            stall_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on accepted requests, check accepted results,
   // and watch for a hang. All sampling is at the rising edge, before the
   // edge's nonblocking updates land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (victim_queue.size() == 0) begin
               $display("%0t: victim way %0d returned with no transaction pending",
                        $time, rsp_chan.victim_way);
               fail_count++;
            end else begin
               want = victim_queue.pop_front();
               checked_victims++;
               if (rsp_chan.victim_way !== want) begin
                  $display("%0t: victim_way mismatch: expected %0d, actual %0d",
                           $time, want, rsp_chan.victim_way);
                  fail_count++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.req_type == OP_VIC) begin
               want = predict_victim(int'(req_chan.set_index) % N_SETS);
               // hand-computed rows override the predictor's answer
               victim_queue.push_back(offer.typed ? offer.victim : want);
            end else begin
               apply_access(int'(req_chan.set_index) % N_SETS,
                            int'(req_chan.way_index) % N_WAYS, req_chan.block_address,
                            req_chan.was_hit, req_chan.random_draw);
               applied_updates++;
            end
         end

         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, giving up", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = OP_VIC;
      req_chan.set_index     = '0;
      req_chan.way_index     = '0;
      req_chan.block_address = '0;
      req_chan.was_hit       = 1'b0;
      req_chan.random_draw   = '0;
      stall_req              = 1'b0;
      fail_count             = 0;
      checked_victims        = 0;
      applied_updates        = 0;
      picks_stream           = 0;
      picks_stream_aged      = 0;
      picks_dead             = 0;
      picks_srrip_aged       = 0;
      send_idle_pct          = 20;
      recv_idle_pct          = 71;

      // predictor at reset: every RRPV at max, nothing dead or streaming
      for (int s = 0; s < N_SETS; s++) begin
         rrpv_rows[s]    = '1;
         dead_rows[s]    = '0;
         stream_flags[s] = 1'b0;
         last_block[s]   = '0;
         gen_last[s]     = '0;
         leader_map[s]   = drr_pkg::KIND_FOLLOW;
      end
      // later leaders override earlier ones on a collision
      for (int i = 0; i < N_LEADERS; i++)
         leader_map[(i * N_SETS / N_LEADERS) % N_SETS] =
            (i < N_LEADERS / 2) ? drr_pkg::KIND_SRRIP : drr_pkg::KIND_BRRIP;
      duel_count = DUEL_MID;
      duel_lo    = DUEL_MID;
      duel_hi    = DUEL_MID;

      // Directed table. Typed victims are read straight off the reset state;
      // the rest go through the predictor.
      //                        op      set    way blk           hit   drw typ vic
      directed_rows.push_back(row_of(OP_VIC, 0,     0, 32'h0,        1'b0, 0,  1, 0));
      directed_rows.push_back(row_of(OP_VIC, 2047,  0, 32'h0,        1'b0, 0,  1, 0));
      // follower fill at the duel midpoint, first address seen in the set
      directed_rows.push_back(row_of(OP_UPD, 2047, 15, 32'hFFFF_FFFF, 1'b0, 31, 0, 0));
      // all-ones to zero wraps to +1: streaming starts, hit takes RRPV 0
      directed_rows.push_back(row_of(OP_UPD, 2047,  0, 32'h0,        1'b1, 0,  0, 0));
      // previous address is zero: detector holds, streaming fill marks dead
      directed_rows.push_back(row_of(OP_UPD, 2047,  1, 32'h1,        1'b0, 5,  0, 0));
      directed_rows.push_back(row_of(OP_VIC, 2047,  0, 32'h0,        1'b0, 0,  0, 0));
      // big jump clears streaming
      directed_rows.push_back(row_of(OP_UPD, 2047,  1, 32'h1234_5678, 1'b0, 9,  0, 0));
      directed_rows.push_back(row_of(OP_VIC, 2047,  0, 32'h0,        1'b0, 0,  0, 0));
      // leader hits move the duel counter both ways
      directed_rows.push_back(row_of(OP_UPD, 0,     7, 32'h40,       1'b1, 0,  0, 0));
      directed_rows.push_back(row_of(OP_UPD, 1024,  3, 32'h80,       1'b1, 0,  0, 0));
      // bimodal insertion: zero draw gives near, anything else distant
      directed_rows.push_back(row_of(OP_UPD, 1024,  5, 32'h200,      1'b0, 0,  0, 0));
      directed_rows.push_back(row_of(OP_UPD, 1024,  6, 32'h300,      1'b0, 31, 0, 0));
      directed_rows.push_back(row_of(OP_UPD, 32,    9, 32'h900,      1'b0, 17, 0, 0));
      directed_rows.push_back(row_of(OP_UPD, 2016,  2, 32'hA00,      1'b0, 1,  0, 0));
      directed_rows.push_back(row_of(OP_VIC, 1024,  0, 32'hFFFF_FFFF, 1'b1, 31, 0, 0));
      directed_rows.push_back(row_of(OP_UPD, 1024,  0, 32'h5555_5555, 1'b1, 21, 0, 0));
      directed_rows.push_back(row_of(OP_UPD, 1024, 15, 32'hAAAA_AAAA, 1'b1, 10, 0, 0));
      directed_rows.push_back(row_of(OP_VIC, 0,     0, 32'h0,        1'b0, 0,  0, 0));
      directed_rows.push_back(row_of(OP_UPD, 1365, 10, 32'h7FFF_FFFF, 1'b0, 21, 0, 0));
      directed_rows.push_back(row_of(OP_UPD, 682,   5, 32'h8000_0000, 1'b0, 10, 0, 0));
      directed_rows.push_back(row_of(OP_VIC, 1365,  0, 32'h0,        1'b0, 0,  0, 0));
      // same block again: delta zero leaves the detector alone
      directed_rows.push_back(row_of(OP_UPD, 1365, 10, 32'h7FFF_FFFF, 1'b1, 0,  0, 0));
      // one step down: streaming, fill marks dead
      directed_rows.push_back(row_of(OP_UPD, 1365, 11, 32'h7FFF_FFFE, 1'b0, 3,  0, 0));
      directed_rows.push_back(row_of(OP_VIC, 1365,  0, 32'h0,        1'b0, 0,  0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ready stays low through the clearing pass; the first offer just waits
      foreach (directed_rows[i])
         send_row(directed_rows[i]);

      // three idling patterns: sender light / receiver heavy, swapped, none
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 71 : 0;
         recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 20 : 0;
         for (int n = 0; n < ITEMS_PER_MODE; n++) begin
            // receiver goes dark while requests keep coming: back up the block
            if (mode == 2 && n == 100)
               stall_req = 1'b1;
            send_row(random_row(mode));
         end
      end
      req_chan.valid <= 1'b0;

      // drain; the watchdog covers a block that never answers
      while (victim_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d victim picks (%0d streaming, %0d streaming after aging, %0d dead,",
               checked_victims, picks_stream, picks_stream_aged, picks_dead);
      $display("  %0d SRRIP with aging) and %0d updates; duel counter ranged %0d to %0d",
               picks_srrip_aged, applied_updates, duel_lo, duel_hi);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/drr_pkg.sv
rtl/core/drr_if.sv
rtl/core/drr_ram.sv
rtl/core/drr_row_unit.sv
rtl/core/drr_upd_unit.sv
rtl/core/drrip_streaming_dead_block_replacement_unit.sv
test/tb_drrip_streaming_dead_block_replacement_unit.sv
